// ----- rtl/spq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Request and status codes, and the command that is broadcast to every cell
// of the queue chain.
// ----------------------------------------------------------------------------
package spq_pkg;

  // Request kinds carried on the input tuser.
  typedef enum logic [1:0] {
    REQ_QUERY = 2'd0,
    REQ_PUSH  = 2'd1,
    REQ_POP   = 2'd2,
    REQ_CLEAR = 2'd3
  } req_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_POP_EMPTY = 2'd2,
    ST_RSVD      = 2'd3
  } status_t;

  // Field widths fixed by the interface.
  localparam int PRI_W   = 32;
  localparam int TAG_W   = 32;
  localparam int COUNT_W = 5;

  // Command seen by every cell in the cycle a request is accepted.
  typedef struct packed {
    logic                    push;
    logic                    pop;
    logic signed [PRI_W-1:0] pri;
    logic [TAG_W-1:0]        data;
  } cell_cmd_t;

endpackage

// ----- rtl/spq_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted priority queue cell
// Holds one entry; on a push it keeps, takes the new item or takes its left
// neighbor; on a pop it takes its right neighbor.
// ----------------------------------------------------------------------------
module spq_cell #(
  parameter int STORE_W = 32
) (
  input  logic                            clk,
  input  spq_pkg::cell_cmd_t              cmd,
  input  logic                            is_head,
  input  logic                            occ,
  input  logic                            left_ahead,
  input  logic signed [spq_pkg::PRI_W-1:0] left_pri,
  input  logic [STORE_W-1:0]              left_data,
  input  logic signed [spq_pkg::PRI_W-1:0] right_pri,
  input  logic [STORE_W-1:0]              right_data,
  output logic                            ahead,
  output logic signed [spq_pkg::PRI_W-1:0] pri,
  output logic [STORE_W-1:0]              data
);
  import spq_pkg::*;

  // This entry stays ahead of the insertion point. The head also stays ahead
  // on a tie, so an equal new item lands right behind it.
  assign ahead = occ && (is_head ? (pri <= cmd.pri) : (pri < cmd.pri));

  // Entry update.
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      if (!ahead) begin
        if (left_ahead) begin
          pri  <= cmd.pri;
          data <= cmd.data[STORE_W-1:0];
        end else begin
          pri  <= left_pri;
          data <= left_data;
        end
      end
    end else if (cmd.pop) begin
      pri  <= right_pri;
      data <= right_data;
    end
  end

endmodule

// ----- rtl/sorted_priority_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted priority queue
// Bounded min-priority queue kept sorted in a chain of compare-and-shift
// cells, one entry per cell, head in cell 0.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on s_axis: tuser is the request kind (query, push, pop,
//   clear), tdata carries the priority (signed Q16.16) and data tag of a push.
//   Every request gives one result on m_axis: the head entry before the
//   request, the entry count and empty flag after it, and a status code.
//   The result of each accepted request is registered before it shows on
//   m_axis. The block takes one request per cycle while s_axis_tready is
//   high: every cell compares its key with the new priority in parallel and
//   shifts in one step, so the next request sees the updated queue at once.
//   Results pass through an output register and a skid register; when the
//   receiver stalls, one more request is taken into the skid register and
//   s_axis_tready then drops until the receiver drains it.
//   Reset empties the queue and the output stage. No clearing pass is
//   needed; cells beyond the count are never shown.
// ----------------------------------------------------------------------------
module sorted_priority_queue #(
  parameter int QUEUE_DEPTH = 16,
  parameter int DATA_WIDTH  = 32
) (
  input  logic        clk,
  input  logic        rst,
  // Request channel.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // [31:0] item_priority, [63:32] item_data
  input  logic [1:0]  s_axis_tuser,  // [1:0] req_type
  // Result channel.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [31:0] head_priority, [63:32] head_data, [68:64] entry_count,
  // [69] is_empty, [71:70] status
  output logic [71:0] m_axis_tdata
);
  import spq_pkg::*;

  localparam int STORE_W = (DATA_WIDTH < TAG_W) ? DATA_WIDTH : TAG_W;
  localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int RES_W   = 72;

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             accept;
  logic             full;
  logic             empty;
  req_t             req;
  status_t          status_next;
  cell_cmd_t        cmd;

  logic signed [PRI_W-1:0] cell_pri   [QUEUE_DEPTH];
  logic [STORE_W-1:0]      cell_data  [QUEUE_DEPTH];
  logic                    cell_ahead [QUEUE_DEPTH];

  logic signed [PRI_W-1:0] head_pri;
  logic [TAG_W-1:0]        head_tag;
  logic [RES_W-1:0]        res;
  logic [RES_W-1:0]        out_data;
  logic [RES_W-1:0]        skid_data;
  logic                    out_valid;
  logic                    skid_valid;

  assign accept = s_axis_tvalid && s_axis_tready;
  assign req    = req_t'(s_axis_tuser);
  assign full   = (count == CNT_W'(QUEUE_DEPTH));
  assign empty  = (count == '0);

  // Command broadcast to the cells.
  always_comb begin
    cmd.push = accept && (req == REQ_PUSH) && !full;
    cmd.pop  = accept && (req == REQ_POP) && !empty;
    cmd.pri  = s_axis_tdata[31:0];
    cmd.data = s_axis_tdata[63:32];
  end

  // Cell chain.
  genvar gi;
  generate
    for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
      localparam int LEFT  = (gi == 0) ? 0 : gi - 1;
      localparam int RIGHT = (gi == QUEUE_DEPTH - 1) ? gi : gi + 1;
      spq_cell #(
        .STORE_W(STORE_W)
      ) u_cell (
        .clk        (clk),
        .cmd        (cmd),
        .is_head    (gi == 0),
        .occ        (CNT_W'(gi) < count),
        .left_ahead ((gi == 0) ? 1'b1 : cell_ahead[LEFT]),
        .left_pri   (cell_pri[LEFT]),
        .left_data  (cell_data[LEFT]),
        .right_pri  (cell_pri[RIGHT]),
        .right_data (cell_data[RIGHT]),
        .ahead      (cell_ahead[gi]),
        .pri        (cell_pri[gi]),
        .data       (cell_data[gi])
      );
    end
  endgenerate

  // Count and status of the current request.
  always_comb begin
    count_next  = count;
    status_next = ST_OK;
    case (req)
      REQ_PUSH: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          count_next = count + 1'b1;
        end
      end
      REQ_POP: begin
        if (empty) begin
          status_next = ST_POP_EMPTY;
        end else begin
          count_next = count - 1'b1;
        end
      end
      REQ_CLEAR: begin
        count_next = '0;
      end
      default: begin
        count_next = count;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept) begin
      count <= count_next;
    end
  end

  // Result word.
  always_comb begin
    head_pri = empty ? '0 : cell_pri[0];
    head_tag = empty ? '0 : TAG_W'(cell_data[0]);
    res = {status_next, (count_next == '0), COUNT_W'(count_next), head_tag,
           head_pri};
  end

  // Output register with skid stage. No request is taken during reset.
  assign s_axis_tready = !skid_valid && !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (!out_valid || m_axis_tready) begin
        if (skid_valid) begin
          out_data   <= skid_data;
          out_valid  <= 1'b1;
          skid_valid <= 1'b0;
        end else begin
          out_valid <= accept;
          if (accept) begin
            out_data <= res;
          end
        end
      end else if (accept) begin
        skid_data  <= res;
        skid_valid <= 1'b1;
      end
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

endmodule

// ----- rtl/spq_check.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted priority queue checker
// Port-level assertions on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
module spq_check #(
  parameter int QUEUE_DEPTH = 16
) (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [71:0] m_axis_tdata
);
  import spq_pkg::*;

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // Empty flag agrees with the count.
  a_empty: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[69] == (m_axis_tdata[68:64] == '0)))
    else $error("empty flag disagrees with count");

  // A pop on an empty queue shows a zero head and leaves the queue empty.
  a_pop_empty: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tdata[71:70] == ST_POP_EMPTY)
    |-> (m_axis_tdata[63:0] == '0) && m_axis_tdata[69])
    else $error("pop on empty with nonempty result");

  // A dropped push only happens at full depth.
  a_full: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tdata[71:70] == ST_FULL)
    |-> (m_axis_tdata[68:64] == COUNT_W'(QUEUE_DEPTH)))
    else $error("push dropped below full depth");

  // A request accepted with the output idle shows its result next cycle.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && !m_axis_tvalid |=> m_axis_tvalid)
    else $error("result missing one cycle after request");

endmodule

bind sorted_priority_queue spq_check #(
  .QUEUE_DEPTH(QUEUE_DEPTH)
) u_spq_check (
  .clk          (clk),
  .rst          (rst),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);

// ----- tb/sorted_priority_queue_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted priority queue testbench
// Sends query, push, pop and clear requests into the queue and checks every
// result against a cycle-free model of the sorted list, kept in step with the
// requests as they are accepted. The run starts with a short directed part
// and then goes through random phases with different idling on each side.
// ----------------------------------------------------------------------------
module sorted_priority_queue_tb;
  import spq_pkg::*;

  localparam int DEPTH      = 16;
  localparam int PHASE_REQS = 450;
  localparam int HOLD_LEN   = 64;
  localparam int IDLE_LIMIT = 2000;

  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_t;

  typedef struct {
    req_t                    kind;
    logic signed [PRI_W-1:0] pri;
    logic [TAG_W-1:0]        tag;
  } queue_req_t;

  typedef struct {
    logic [PRI_W-1:0]   head_pri;
    logic [TAG_W-1:0]   head_tag;
    logic [COUNT_W-1:0] count;
    logic               empty;
    status_t            status;
  } queue_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = REQ_QUERY;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;

  // Requests waiting to be offered and results waiting to arrive.
  queue_req_t    pending_reqs[$];
  queue_result_t expected_results[$];
  queue_req_t    current_req;

  // Shadow copy of the sorted list.
  logic signed [PRI_W-1:0] shadow_pri[DEPTH];
  logic [TAG_W-1:0]        shadow_tag[DEPTH];
  int                      shadow_count = 0;

  idle_mode_t idle_mode = IDLE_NONE;
  int         queued_total = 0;
  int         results_seen = 0;
  int         error_count = 0;
  int         hold_ticket = 0;
  int         hold_seen = 0;
  int         hold_left = 0;
  int         idle_cycles = 0;
  int         kind_tally[4] = '{0, 0, 0, 0};
  int         full_drops = 0;
  int         empty_pops = 0;
  int         peak_count = 0;

  sorted_priority_queue #(
    .QUEUE_DEPTH(DEPTH),
    .DATA_WIDTH (TAG_W)
  ) u_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Apply one request to the shadow list and return the result it must give.
  function automatic queue_result_t apply_to_shadow(input queue_req_t rq);
    queue_result_t res;
    int pos;
    int i;
    res.head_pri = (shadow_count > 0) ? shadow_pri[0] : '0;
    res.head_tag = (shadow_count > 0) ? shadow_tag[0] : '0;
    res.status   = ST_OK;
    case (rq.kind)
      REQ_PUSH: begin
        if (shadow_count >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          // A tie with the head lands right behind it, never in front.
          pos = 0;
          if (shadow_count > 0 && shadow_pri[0] <= rq.pri) begin
            pos = 1;
            while (pos < shadow_count && shadow_pri[pos] < rq.pri) pos++;
          end
          for (i = shadow_count; i > pos; i--) begin
            shadow_pri[i] = shadow_pri[i-1];
            shadow_tag[i] = shadow_tag[i-1];
          end
          shadow_pri[pos] = rq.pri;
          shadow_tag[pos] = rq.tag;
          shadow_count++;
        end
      end
      REQ_POP: begin
        if (shadow_count == 0) begin
          res.status = ST_POP_EMPTY;
        end else begin
          for (i = 0; i + 1 < shadow_count; i++) begin
            shadow_pri[i] = shadow_pri[i+1];
            shadow_tag[i] = shadow_tag[i+1];
          end
          shadow_count--;
        end
      end
      REQ_CLEAR: shadow_count = 0;
      default: ;
    endcase
    res.count = shadow_count[COUNT_W-1:0];
    res.empty = (shadow_count == 0);
    return res;
  endfunction

  function automatic bit gap_now(input bit sender_side);
    int roll;
    roll = $urandom_range(0, 99);
    case (idle_mode)
      IDLE_SENDER:   return sender_side && roll < 68;
      IDLE_RECEIVER: return !sender_side && roll < 68;
      IDLE_BOTH:     return roll < 10;
      default:       return 1'b0;
    endcase
  endfunction

  function automatic void flag_field(input string field_name, input logic [31:0] want,
                                     input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field_name, want, got);
      error_count++;
    end
  endfunction

  // Driver: offers the next pending request and predicts each accepted one.
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_results.push_back(apply_to_shadow(current_req));
        kind_tally[current_req.kind]++;
        if (expected_results[$].status == ST_FULL) full_drops++;
        if (expected_results[$].status == ST_POP_EMPTY) empty_pops++;
        if (shadow_count > peak_count) peak_count = shadow_count;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_reqs.size() > 0 && !gap_now(1'b1)) begin
          current_req = pending_reqs.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {current_req.tag, current_req.pri};
          s_axis_tuser  <= current_req.kind;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks every accepted result and drives the ready side.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: result %h arrived with nothing expected, expected none, actual %h",
                 $time, m_axis_tdata, m_axis_tdata);
        error_count++;
      end else begin
        flag_field("head_priority", expected_results[0].head_pri, m_axis_tdata[31:0]);
        flag_field("head_data", expected_results[0].head_tag, m_axis_tdata[63:32]);
        flag_field("entry_count", expected_results[0].count, m_axis_tdata[68:64]);
        flag_field("is_empty", expected_results[0].empty, m_axis_tdata[69]);
        flag_field("status", expected_results[0].status, m_axis_tdata[71:70]);
        void'(expected_results.pop_front());
      end
      results_seen++;
    end
    // A long hold-off is counted here once the stimulus asks for one.
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_ticket != hold_seen) begin
      hold_seen <= hold_ticket;
      hold_left <= HOLD_LEN;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= !gap_now(1'b0);
    end
  end

  // Watchdog on cycles in which neither side moves a request or result.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic add_req(input req_t kind, input logic [31:0] pri, input logic [31:0] tag);
    queue_req_t rq;
    rq.kind = kind;
    rq.pri  = pri;
    rq.tag  = tag;
    pending_reqs.push_back(rq);
    queued_total++;
  endtask

  // Keys are mostly drawn from a few whole values so that ties are common.
  function automatic logic [31:0] pick_priority();
    int roll;
    int k;
    roll = $urandom_range(0, 99);
    k = $urandom_range(0, 6);
    if (roll < 40) return (k - 3) * 65536;
    if (roll < 70) return $urandom;
    if (roll < 82) begin
      case (k % 4)
        0: return 32'h7FFF_FFFF;
        1: return 32'h8000_0000;
        2: return 32'h0000_0000;
        default: return 32'hFFFF_FFFF;
      endcase
    end
    return $urandom_range(0, 255) - 128;
  endfunction

  // Random requests in bursts: fill runs, drain runs, mixed runs, clears.
  task automatic add_random_reqs(input int n);
    int added;
    int roll;
    int len;
    req_t kind;
    added = 0;
    while (added < n) begin
      roll = $urandom_range(0, 99);
      len  = $urandom_range(1, 20);
      repeat (len) begin
        if ($urandom_range(0, 9) == 0) kind = REQ_QUERY;
        else if (roll < 45) kind = REQ_PUSH;
        else if (roll < 85) kind = REQ_POP;
        else kind = req_t'($urandom_range(0, 2));
        add_req(kind, pick_priority(), $urandom);
        added++;
      end
      if (roll >= 97) begin
        add_req(REQ_CLEAR, $urandom, $urandom);
        added++;
      end
    end
  endtask

  task automatic wait_drained();
    wait (results_seen == queued_total);
    @(posedge clk);
  endtask

  initial begin
    int i;
    idle_mode_t mode;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed part: empty queue, extremes, ties behind the head, full queue.
    add_req(REQ_QUERY, 32'h0, 32'h0);
    add_req(REQ_POP, 32'h0, 32'h0);
    add_req(REQ_PUSH, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    add_req(REQ_PUSH, 32'h8000_0000, 32'h0000_0000);
    add_req(REQ_PUSH, 32'h8000_0000, 32'hA5A5_A5A5);
    add_req(REQ_PUSH, 32'h0000_0000, 32'h5A5A_5A5A);
    add_req(REQ_POP, 32'h0, 32'h0);
    add_req(REQ_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    for (i = 0; i < DEPTH + 1; i++) begin
      add_req(REQ_PUSH, ((i % 4) - 1) * 65536, i);
    end
    wait_drained();

    // Random phases, each with its own idling on the two sides.
    for (i = 0; i < 4; i++) begin
      mode = idle_mode_t'(i);
      idle_mode = mode;
      add_random_reqs(PHASE_REQS);
      if (mode == IDLE_NONE) begin
        // Let the sender keep offering while the receiver holds off.
        wait (pending_reqs.size() < PHASE_REQS - 40);
        @(posedge clk);
        hold_ticket <= hold_ticket + 1;
      end
      wait_drained();
    end
    repeat (4) @(posedge clk);

    if (expected_results.size() != 0) begin
      $display("%0t: %0d results never arrived, expected 0, actual %0d", $time,
               expected_results.size(), expected_results.size());
      error_count++;
    end
    $display("Checked %0d results: %0d query, %0d push, %0d pop, %0d clear requests.",
             results_seen, kind_tally[REQ_QUERY], kind_tally[REQ_PUSH],
             kind_tally[REQ_POP], kind_tally[REQ_CLEAR]);
    $display("Dropped pushes %0d, pops on empty %0d, peak fill %0d, mismatches %0d.",
             full_drops, empty_pops, peak_count, error_count);
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
